[rtl/epse_pkg.sv]
`timescale 1ns / 1ps

package epse_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned NUMER_W = 24;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned SPEED_W = 33;
    localparam int unsigned STEP_W  = 5;

    localparam logic [NUMER_W-1:0] NUMER_RESET    = 24'd200000;
    localparam logic               POLARITY_RESET = 1'b1;
    localparam logic [TIME_W-1:0]  MAG_SAT        = 32'hFFFF_FFFF;
    localparam logic [STEP_W-1:0]  LAST_STEP      = 5'd31;

    localparam logic CFG_SPEED_NUMERATOR  = 1'b0;
    localparam logic CFG_REVERSE_POLARITY = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              phase_a_level;
    } epse_in_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      direction;
        logic                      direction_changed;
    } epse_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } epse_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } epse_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_full;
    } epse_status_t;

endpackage

[rtl/encoder_period_speed_estimator_unit.sv]
`timescale 1ns / 1ps

// Each input beat is one rising edge of encoder channel B with its microsecond timestamp and the
// sampled channel A level; the block returns one result beat with the signed speed (8 fraction
// bits), the direction and a direction-change flag. The magnitude is the speed numerator shifted
// left by 8 and divided by the period since the previous edge, computed by a restoring divider
// that retires one quotient bit per cycle. An edge is accepted, takes 32 divide steps, and loads
// the output register when it is empty or being read; a finished result waits there while the
// next edge is accepted. A zero period saturates the magnitude, and a direction change
// forces the speed to zero. Configuration writes take effect at once and are meant for idle time.
module encoder_period_speed_estimator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  epse_pkg::epse_in_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output epse_pkg::epse_out_t out_beat
);

    epse_pkg::epse_cmd_t    cmd;
    epse_pkg::epse_status_t status;

    epse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    epse_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule

[rtl/epse_ctrl.sv]
`timescale 1ns / 1ps

module epse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  epse_pkg::epse_status_t status,
    output epse_pkg::epse_cmd_t    cmd
);

    epse_pkg::epse_state_t state_reg;
    epse_pkg::epse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            epse_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = epse_pkg::ST_DIV;
                end
            end
            epse_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = epse_pkg::ST_DONE;
                end
            end
            epse_pkg::ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.store  = 1'b1;
                    state_next = epse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = epse_pkg::ST_IDLE;
            end
        endcase
    end

    a_store_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> state_reg == epse_pkg::ST_IDLE)
        else $error("store did not return the controller to idle");

    a_div_leads_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.div_last) |=> state_reg == epse_pkg::ST_DONE)
        else $error("last divide step did not reach the done state");

    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == epse_pkg::ST_DIV)
        else $error("accepted beat did not start the divider");

endmodule

[rtl/epse_dp.sv]
`timescale 1ns / 1ps

module epse_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [23:0]           cfg_data,
    input  epse_pkg::epse_in_t    in_beat,
    input  epse_pkg::epse_cmd_t   cmd,
    output epse_pkg::epse_status_t status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output epse_pkg::epse_out_t   out_beat
);

    logic [epse_pkg::NUMER_W-1:0] numer_reg;
    logic                         polarity_reg;
    logic [epse_pkg::TIME_W-1:0]  last_time_reg;
    logic                         last_dir_reg;

    logic [epse_pkg::TIME_W-1:0]  divisor_reg;
    logic [epse_pkg::TIME_W-1:0]  rem_reg;
    logic [epse_pkg::TIME_W-1:0]  rem_next;
    logic [epse_pkg::TIME_W-1:0]  quo_reg;
    logic [epse_pkg::TIME_W-1:0]  quo_next;
    logic [epse_pkg::STEP_W-1:0]  cnt_reg;
    logic                         zero_reg;
    logic                         neg_reg;
    logic                         dir_reg;
    logic                         changed_reg;

    logic [epse_pkg::TIME_W:0]    rem_shift;
    logic [epse_pkg::TIME_W+1:0]  trial;
    logic [epse_pkg::TIME_W-1:0]  delta;
    logic [epse_pkg::TIME_W-1:0]  mag;
    logic [epse_pkg::SPEED_W-1:0] mag_ext;

    logic                         out_valid_reg;
    epse_pkg::epse_out_t          out_reg;

    assign delta     = in_beat.edge_time - last_time_reg;
    assign rem_shift = {rem_reg, quo_reg[epse_pkg::TIME_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};

    always_comb
    begin
        if (trial[epse_pkg::TIME_W+1])
        begin
            rem_next = rem_shift[epse_pkg::TIME_W-1:0];
            quo_next = {quo_reg[epse_pkg::TIME_W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[epse_pkg::TIME_W-1:0];
            quo_next = {quo_reg[epse_pkg::TIME_W-2:0], 1'b1};
        end
    end

    assign mag     = zero_reg ? epse_pkg::MAG_SAT : quo_reg;
    assign mag_ext = {1'b0, mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numer_reg    <= epse_pkg::NUMER_RESET;
            polarity_reg <= epse_pkg::POLARITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epse_pkg::CFG_SPEED_NUMERATOR:  numer_reg    <= cfg_data;
                epse_pkg::CFG_REVERSE_POLARITY: polarity_reg <= cfg_data[0];
                default:                        numer_reg    <= numer_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            last_dir_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (cmd.load)
        begin
            last_time_reg <= in_beat.edge_time;
            last_dir_reg  <= in_beat.phase_a_level;
            cnt_reg       <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            divisor_reg <= delta;
            rem_reg     <= '0;
            quo_reg     <= {numer_reg, {epse_pkg::FRAC_W{1'b0}}};
            zero_reg    <= (delta == '0);
            neg_reg     <= (in_beat.phase_a_level == polarity_reg);
            dir_reg     <= in_beat.phase_a_level;
            changed_reg <= (in_beat.phase_a_level != last_dir_reg);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.div_last = (cnt_reg == epse_pkg::LAST_STEP);
    assign status.out_full = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.store)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (changed_reg)
            begin
                out_reg.speed <= '0;
            end
            else if (neg_reg)
            begin
                out_reg.speed <= $signed(-mag_ext);
            end
            else
            begin
                out_reg.speed <= $signed(mag_ext);
            end
            out_reg.direction         <= dir_reg;
            out_reg.direction_changed <= changed_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten before its beat was taken");

    a_changed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.direction_changed) |-> out_reg.speed == '0)
        else $error("nonzero speed on a direction change");

    a_load_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cnt_reg == '0)
        else $error("divide step count not cleared on load");

endmodule
